>>> hw/rtl/websocket_frame_deframer_macros.svh
// Assertion macros used by the deframer core (wsd_core).
`ifndef WEBSOCKET_FRAME_DEFRAMER_MACROS_SVH
`define WEBSOCKET_FRAME_DEFRAMER_MACROS_SVH

`ifndef SYNTH

// same-cycle implication, disabled while in reset
`define WSD_ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("deframer assertion failed");

// next-cycle implication, disabled while in reset
`define WSD_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("deframer assertion failed");

`else

`define WSD_ASSERT_SAME(label, clk, rst_n, ante, cons)
`define WSD_ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

>>> hw/rtl/wsd_pkg.sv
// Types and constants of the WebSocket frame deframer.
package wsd_pkg;

    // header field codes
    localparam logic [3:0] OPC_TEXT  = 4'h1;
    localparam logic [3:0] OPC_CLOSE = 4'h8;
    localparam logic [6:0] LEN_EXT16 = 7'd126;
    localparam logic [6:0] LEN_EXT64 = 7'd127;

    // decode phase
    typedef enum logic [2:0] {
        PH_HDR0 = 3'd0,
        PH_HDR1 = 3'd1,
        PH_EXT  = 3'd2,
        PH_MASK = 3'd3,
        PH_PAY  = 3'd4,
        PH_DROP = 3'd5
    } t_phase;

    // result status
    typedef enum logic [2:0] {
        ST_OK        = 3'd0,
        ST_CLOSE     = 3'd1,
        ST_BADOP     = 3'd2,
        ST_TOOLONG   = 3'd3,
        ST_TRUNC_LEN = 3'd4,
        ST_TRUNC_MSK = 3'd5,
        ST_TRUNC_PAY = 3'd6
    } t_status;

    // one received byte beat
    typedef struct packed {
        logic [7:0] rx_byte;
        logic       buffer_end;
    } t_in_beat;

    // one result beat
    typedef struct packed {
        logic [7:0] payload_byte;
        logic       has_byte;
        logic       frame_last;
        t_status    status;
    } t_result;

endpackage

>>> hw/rtl/wsd_if.sv
// Stream interfaces of the deframer: received bytes in, results out.
interface wsd_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] rx_byte;
    logic       buffer_end;

    modport source (output valid, output rx_byte, output buffer_end, input ready);
    modport sink   (input valid, input rx_byte, input buffer_end, output ready);
endinterface

interface wsd_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] payload_byte;
    logic       has_byte;
    logic       frame_last;
    logic [2:0] status;

    modport source (output valid, output payload_byte, output has_byte,
                    output frame_last, output status, input ready);
    modport sink   (input valid, input payload_byte, input has_byte,
                    input frame_last, input status, output ready);
endinterface

>>> hw/rtl/wsd_in_stage.sv
// Input register stage: holds one received byte beat for the decoder.
module wsd_in_stage (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_ready,
    input  wsd_pkg::t_in_beat i_beat,
    output logic              o_valid,
    input  logic              i_take,
    output wsd_pkg::t_in_beat o_beat
);
    import wsd_pkg::*;

    logic     r_valid;
    t_in_beat r_beat;

    // free when empty or when the held beat leaves this cycle
    assign o_ready = !r_valid || i_take;
    assign o_valid = r_valid;
    assign o_beat  = r_beat;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    // payload, no reset
    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_beat <= i_beat;
        end
    end

endmodule

>>> hw/rtl/wsd_core.sv
// Frame decode state and per-byte step logic.
`include "websocket_frame_deframer_macros.svh"

module wsd_core (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_take,
    input  wsd_pkg::t_in_beat i_beat,
    output logic              o_emit,
    output wsd_pkg::t_result  o_res
);
    import wsd_pkg::*;

    t_phase      r_phase, n_phase;
    logic        r_masked, n_masked;
    logic        r_ext_cnt, n_ext_cnt;
    logic [15:0] r_rem, n_rem;
    logic [31:0] r_key, n_key;
    logic [1:0]  r_idx, n_idx;

    logic [7:0]  w_b;
    logic        w_end;
    logic [3:0]  w_opc;
    logic [6:0]  w_len7;
    logic [15:0] w_ext_rem;
    logic [15:0] w_rem_dec;
    logic [7:0]  w_key_byte;
    logic [7:0]  w_unmasked;
    logic        w_bad_op;

    assign w_b        = i_beat.rx_byte;
    assign w_end      = i_beat.buffer_end;
    assign w_opc      = w_b[3:0];
    assign w_len7     = w_b[6:0];
    assign w_ext_rem  = {r_rem[15:8], w_b};
    assign w_rem_dec  = (r_rem != 16'd0) ? (r_rem - 16'd1) : r_rem;
    assign w_key_byte = 8'(r_key >> {r_idx, 3'b000});
    assign w_unmasked = r_masked ? (w_b ^ w_key_byte) : w_b;
    assign w_bad_op   = (w_opc != OPC_TEXT);

    // next phase: any beat with buffer_end returns to the first header byte
    always_comb begin
        n_phase = r_phase;
        if (w_end) begin
            n_phase = PH_HDR0;
        end else begin
            case (r_phase)
                PH_HDR0: n_phase = w_bad_op ? PH_DROP : PH_HDR1;
                PH_HDR1: begin
                    if (w_len7 == LEN_EXT64)      n_phase = PH_DROP;
                    else if (w_len7 == LEN_EXT16) n_phase = PH_EXT;
                    else if (w_b[7])              n_phase = PH_MASK;
                    else if (w_len7 == 7'd0)      n_phase = PH_DROP;
                    else                          n_phase = PH_PAY;
                end
                PH_EXT: begin
                    if (!r_ext_cnt)               n_phase = PH_EXT;
                    else if (r_masked)            n_phase = PH_MASK;
                    else if (w_ext_rem == 16'd0)  n_phase = PH_DROP;
                    else                          n_phase = PH_PAY;
                end
                PH_MASK: begin
                    if (r_idx != 2'd3)            n_phase = PH_MASK;
                    else if (r_rem == 16'd0)      n_phase = PH_DROP;
                    else                          n_phase = PH_PAY;
                end
                PH_PAY:  n_phase = (w_rem_dec == 16'd0) ? PH_DROP : PH_PAY;
                PH_DROP: n_phase = PH_DROP;
                default: n_phase = PH_HDR0;
            endcase
        end
    end

    // result of this beat
    always_comb begin
        o_emit = 1'b0;
        o_res  = '{payload_byte: 8'd0, has_byte: 1'b0, frame_last: 1'b1, status: ST_OK};
        case (r_phase)
            PH_HDR0: begin
                if (w_opc == OPC_CLOSE) begin
                    o_emit = 1'b1;  o_res.status = ST_CLOSE;
                end else if (w_bad_op) begin
                    o_emit = 1'b1;  o_res.status = ST_BADOP;
                end else if (w_end) begin
                    o_emit = 1'b1;  o_res.status = ST_TRUNC_LEN;
                end
            end
            PH_HDR1: begin
                if (w_len7 == LEN_EXT64) begin
                    o_emit = 1'b1;  o_res.status = ST_TOOLONG;
                end else if (w_len7 == LEN_EXT16) begin
                    if (w_end) begin
                        o_emit = 1'b1;  o_res.status = ST_TRUNC_LEN;
                    end
                end else if (w_b[7]) begin
                    if (w_end) begin
                        o_emit = 1'b1;  o_res.status = ST_TRUNC_MSK;
                    end
                end else if (w_len7 == 7'd0) begin
                    o_emit = 1'b1;  o_res.status = ST_OK;
                end else if (w_end) begin
                    o_emit = 1'b1;  o_res.status = ST_TRUNC_PAY;
                end
            end
            PH_EXT: begin
                if (!r_ext_cnt) begin
                    if (w_end) begin
                        o_emit = 1'b1;  o_res.status = ST_TRUNC_LEN;
                    end
                end else if (r_masked) begin
                    if (w_end) begin
                        o_emit = 1'b1;  o_res.status = ST_TRUNC_MSK;
                    end
                end else if (w_ext_rem == 16'd0) begin
                    o_emit = 1'b1;  o_res.status = ST_OK;
                end else if (w_end) begin
                    o_emit = 1'b1;  o_res.status = ST_TRUNC_PAY;
                end
            end
            PH_MASK: begin
                if (r_idx == 2'd3) begin
                    if (r_rem == 16'd0) begin
                        o_emit = 1'b1;  o_res.status = ST_OK;
                    end else if (w_end) begin
                        o_emit = 1'b1;  o_res.status = ST_TRUNC_PAY;
                    end
                end else if (w_end) begin
                    o_emit = 1'b1;  o_res.status = ST_TRUNC_MSK;
                end
            end
            PH_PAY: begin
                o_emit = 1'b1;
                if (w_rem_dec == 16'd0) begin
                    o_res.payload_byte = w_unmasked;
                    o_res.has_byte     = 1'b1;
                end else if (w_end) begin
                    o_res.status = ST_TRUNC_PAY;
                end else begin
                    o_res.payload_byte = w_unmasked;
                    o_res.has_byte     = 1'b1;
                    o_res.frame_last   = 1'b0;
                end
            end
            default: o_emit = 1'b0;
        endcase
    end

    // header fields, key and counters
    always_comb begin
        n_masked  = r_masked;
        n_ext_cnt = r_ext_cnt;
        n_rem     = r_rem;
        n_key     = r_key;
        n_idx     = r_idx;
        case (r_phase)
            PH_HDR0: begin
                n_masked  = 1'b0;
                n_ext_cnt = 1'b0;
                n_rem     = 16'd0;
                n_key     = 32'd0;
                n_idx     = 2'd0;
            end
            PH_HDR1: begin
                n_masked = w_b[7];
                if (w_len7 == LEN_EXT16) begin
                    n_ext_cnt = 1'b0;
                end else if (w_len7 != LEN_EXT64) begin
                    n_rem = {9'd0, w_len7};
                    n_idx = 2'd0;
                end
            end
            PH_EXT: begin
                if (!r_ext_cnt) begin
                    n_rem     = {w_b, 8'd0};
                    n_ext_cnt = 1'b1;
                end else begin
                    n_rem     = w_ext_rem;
                    n_ext_cnt = 1'b0;
                    if (r_masked) begin
                        n_idx = 2'd0;
                    end
                end
            end
            PH_MASK: begin
                n_key = r_key | ({24'd0, w_b} << {r_idx, 3'b000});
                n_idx = r_idx + 2'd1;
            end
            PH_PAY: begin
                n_rem = w_rem_dec;
                n_idx = r_idx + 2'd1;
            end
            default: n_idx = r_idx;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase   <= PH_HDR0;
            r_masked  <= 1'b0;
            r_ext_cnt <= 1'b0;
            r_idx     <= 2'd0;
            r_rem     <= 16'd0;
            r_key     <= 32'd0;
        end else if (i_take) begin
            r_phase   <= n_phase;
            r_masked  <= n_masked;
            r_ext_cnt <= n_ext_cnt;
            r_idx     <= n_idx;
            r_rem     <= n_rem;
            r_key     <= n_key;
        end
    end

    // payload bytes only come out of the payload phase
    `WSD_ASSERT_SAME(a_byte_in_payload, i_clk, i_rst_n,
        i_take && o_emit && o_res.has_byte, r_phase == PH_PAY)
    // error and close results carry no byte and end the frame
    `WSD_ASSERT_SAME(a_err_is_last, i_clk, i_rst_n,
        i_take && o_emit && (o_res.status != ST_OK), o_res.frame_last && !o_res.has_byte)
    // a buffer end always rearms the header decode
    `WSD_ASSERT_NEXT(a_end_rearms, i_clk, i_rst_n,
        i_take && w_end, r_phase == PH_HDR0)

endmodule

>>> hw/rtl/wsd_out_stage.sv
// Result register stage: holds one result beat until the consumer takes it.
module wsd_out_stage (
    input  logic             i_clk,
    input  logic             i_rst_n,
    output logic             o_ready,
    input  logic             i_load,
    input  wsd_pkg::t_result i_res,
    output logic             o_valid,
    input  logic             i_ready,
    output wsd_pkg::t_result o_res
);
    import wsd_pkg::*;

    logic    r_valid;
    t_result r_res;

    // free when empty or when the held result leaves this cycle
    assign o_ready = !r_valid || i_ready;
    assign o_valid = r_valid;
    assign o_res   = r_res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_load;
        end
    end

    // payload, no reset
    always_ff @(posedge i_clk) begin
        if (o_ready && i_load) begin
            r_res <= i_res;
        end
    end

endmodule

>>> hw/rtl/websocket_frame_deframer.sv
// WebSocket frame deframer top level: decodes the first frame of each received buffer,
// taking one byte beat per cycle. A byte passes an input register, the decode step and a
// result register, which holds its result until the consumer takes it, and bytes
// are accepted every cycle as long as the result side keeps taking beats; the result
// register is the only point of backpressure. Only text frames are decoded: close and
// other opcodes, a 64-bit length code and early buffer ends each give one status beat
// with frame_last set. Payload bytes are unmasked and streamed as they arrive, so on a
// truncated payload status the consumer must discard the bytes already received.
module websocket_frame_deframer (
    input  logic       i_clk,
    input  logic       i_rst_n,
    wsd_in_if.sink     i_rx,
    wsd_out_if.source  o_frm
);
    import wsd_pkg::*;

    t_in_beat w_in_beat;
    t_in_beat w_dec_beat;
    t_result  w_dec_res;
    t_result  w_out_res;
    logic     w_dec_valid;
    logic     w_dec_emit;
    logic     w_out_free;
    logic     w_take;

    assign w_in_beat = '{rx_byte: i_rx.rx_byte, buffer_end: i_rx.buffer_end};
    assign w_take    = w_dec_valid && w_out_free;

    wsd_in_stage u_in (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_rx.valid),
        .o_ready (i_rx.ready),
        .i_beat  (w_in_beat),
        .o_valid (w_dec_valid),
        .i_take  (w_take),
        .o_beat  (w_dec_beat)
    );

    wsd_core u_core (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_take  (w_take),
        .i_beat  (w_dec_beat),
        .o_emit  (w_dec_emit),
        .o_res   (w_dec_res)
    );

    wsd_out_stage u_out (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .o_ready (w_out_free),
        .i_load  (w_take && w_dec_emit),
        .i_res   (w_dec_res),
        .o_valid (o_frm.valid),
        .i_ready (o_frm.ready),
        .o_res   (w_out_res)
    );

    assign o_frm.payload_byte = w_out_res.payload_byte;
    assign o_frm.has_byte     = w_out_res.has_byte;
    assign o_frm.frame_last   = w_out_res.frame_last;
    assign o_frm.status       = w_out_res.status;

endmodule

>>> tb/tb_websocket_frame_deframer.sv
// Testbench of the WebSocket frame deframer: directed and random byte buffers checked beat by beat.
module tb_websocket_frame_deframer;
    import wsd_pkg::*;

    localparam int unsigned RANDOM_BEATS  = 1700;
    localparam int unsigned MAX_WAIT      = 18;
    localparam int unsigned SETTLE_CYCLES = 10;
    localparam int unsigned RUN_LIMIT     = 20 * 400000;

    // Frame decoder copy plus the queue of result beats it predicts
    class deframe_scoreboard;
        t_phase      phase;
        bit          masked;
        bit          ext_hi_done;
        logic [15:0] remaining;
        logic [31:0] key;
        logic [1:0]  key_idx;
        t_result     expected_q[$];
        int unsigned mismatch_count;

        function new();
            phase          = PH_HDR0;
            masked         = 1'b0;
            ext_hi_done    = 1'b0;
            remaining      = '0;
            key            = '0;
            key_idx        = '0;
            mismatch_count = 0;
        endfunction

        function t_result make_result(logic [7:0] pb, logic has, logic last, t_status st);
            t_result r;
            r.payload_byte = pb;
            r.has_byte     = has;
            r.frame_last   = last;
            r.status       = st;
            return r;
        endfunction

        // length known and mask key in: either done, truncated, or on to payload
        function bit finish_header(logic e, output t_result r);
            if (remaining == 0) begin
                phase = e ? PH_HDR0 : PH_DROP;
                r = make_result(8'h00, 1'b0, 1'b1, ST_OK);
                return 1'b1;
            end
            if (e) begin
                phase = PH_HDR0;
                r = make_result(8'h00, 1'b0, 1'b1, ST_TRUNC_PAY);
                return 1'b1;
            end
            phase = PH_PAY;
            return 1'b0;
        endfunction

        function bit after_length(logic e, output t_result r);
            if (masked) begin
                if (e) begin
                    phase = PH_HDR0;
                    r = make_result(8'h00, 1'b0, 1'b1, ST_TRUNC_MSK);
                    return 1'b1;
                end
                key_idx = '0;
                phase   = PH_MASK;
                return 1'b0;
            end
            return finish_header(e, r);
        endfunction

        // one received byte; returns 1 when it yields a result beat
        function bit decode_byte(logic [7:0] b, logic e, output t_result r);
            logic [6:0] len_code;
            logic [7:0] pb;
            case (phase)
                PH_HDR0: begin
                    masked      = 1'b0;
                    ext_hi_done = 1'b0;
                    remaining   = '0;
                    key         = '0;
                    key_idx     = '0;
                    if (b[3:0] == OPC_CLOSE) begin
                        phase = e ? PH_HDR0 : PH_DROP;
                        r = make_result(8'h00, 1'b0, 1'b1, ST_CLOSE);
                        return 1'b1;
                    end
                    if (b[3:0] != OPC_TEXT) begin
                        phase = e ? PH_HDR0 : PH_DROP;
                        r = make_result(8'h00, 1'b0, 1'b1, ST_BADOP);
                        return 1'b1;
                    end
                    if (e) begin
                        phase = PH_HDR0;
                        r = make_result(8'h00, 1'b0, 1'b1, ST_TRUNC_LEN);
                        return 1'b1;
                    end
                    phase = PH_HDR1;
                    return 1'b0;
                end
                PH_HDR1: begin
                    masked   = b[7];
                    len_code = b[6:0];
                    if (len_code == LEN_EXT64) begin
                        phase = e ? PH_HDR0 : PH_DROP;
                        r = make_result(8'h00, 1'b0, 1'b1, ST_TOOLONG);
                        return 1'b1;
                    end
                    if (len_code == LEN_EXT16) begin
                        if (e) begin
                            phase = PH_HDR0;
                            r = make_result(8'h00, 1'b0, 1'b1, ST_TRUNC_LEN);
                            return 1'b1;
                        end
                        ext_hi_done = 1'b0;
                        phase       = PH_EXT;
                        return 1'b0;
                    end
                    remaining = {9'd0, len_code};
                    return after_length(e, r);
                end
                PH_EXT: begin
                    if (!ext_hi_done) begin
                        remaining   = {b, 8'h00};
                        ext_hi_done = 1'b1;
                        if (e) begin
                            phase = PH_HDR0;
                            r = make_result(8'h00, 1'b0, 1'b1, ST_TRUNC_LEN);
                            return 1'b1;
                        end
                        return 1'b0;
                    end
                    remaining   = remaining | {8'h00, b};
                    ext_hi_done = 1'b0;
                    return after_length(e, r);
                end
                PH_MASK: begin
                    key = key | ({24'd0, b} << (8 * key_idx));
                    if (key_idx == 2'd3) begin
                        key_idx = '0;
                        return finish_header(e, r);
                    end
                    key_idx = key_idx + 2'd1;
                    if (e) begin
                        phase = PH_HDR0;
                        r = make_result(8'h00, 1'b0, 1'b1, ST_TRUNC_MSK);
                        return 1'b1;
                    end
                    return 1'b0;
                end
                PH_PAY: begin
                    pb = masked ? (b ^ key[8 * key_idx +: 8]) : b;
                    key_idx = key_idx + 2'd1;
                    if (remaining > 0) remaining = remaining - 16'd1;
                    if (remaining == 0) begin
                        phase = e ? PH_HDR0 : PH_DROP;
                        r = make_result(pb, 1'b1, 1'b1, ST_OK);
                        return 1'b1;
                    end
                    if (e) begin
                        phase = PH_HDR0;
                        r = make_result(8'h00, 1'b0, 1'b1, ST_TRUNC_PAY);
                        return 1'b1;
                    end
                    r = make_result(pb, 1'b1, 1'b0, ST_OK);
                    return 1'b1;
                end
                default: begin
                    // trailing bytes: dropped until the buffer ends
                    if (e) phase = PH_HDR0;
                    return 1'b0;
                end
            endcase
        endfunction

        function void note_rx_beat(logic [7:0] b, logic e);
            t_result r;
            if (decode_byte(b, e, r)) expected_q = {expected_q, r};
        endfunction

        task report_mismatch(string what, int unsigned exp_v, int unsigned got_v);
            $display("[%0t] mismatch %s: expected %0h got %0h", $time, what, exp_v, got_v);
            mismatch_count++;
        endtask

        task check_result(t_result got);
            t_result exp_r;
            if (expected_q.size() == 0) begin
                report_mismatch("unexpected result beat", 0, got);
                return;
            end
            exp_r = expected_q.pop_front();
            if (got.payload_byte !== exp_r.payload_byte)
                report_mismatch("payload_byte", exp_r.payload_byte, got.payload_byte);
            if (got.has_byte !== exp_r.has_byte)
                report_mismatch("has_byte", exp_r.has_byte, got.has_byte);
            if (got.frame_last !== exp_r.frame_last)
                report_mismatch("frame_last", exp_r.frame_last, got.frame_last);
            if (got.status !== exp_r.status)
                report_mismatch("status", exp_r.status, got.status);
        endtask
    endclass

    logic i_clk = 1'b0;
    logic i_rst_n;

    wsd_in_if  rx_if ();
    wsd_out_if frm_if ();

    deframe_scoreboard sb;
    bit                steady;
    int unsigned       beats_sent;

    websocket_frame_deframer uut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_rx    (rx_if),
        .o_frm   (frm_if)
    );

    always #10 i_clk = ~i_clk;

    // One byte beat, after a random gap with valid low unless in steady mode
    task automatic send_beat(input logic [7:0] b, input logic last);
        int unsigned gap;
        gap = steady ? 0 : $urandom_range(0, MAX_WAIT);
        if (gap > 0) begin
            rx_if.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        rx_if.valid      <= 1'b1;
        rx_if.rx_byte    <= b;
        rx_if.buffer_end <= last;
        do @(posedge i_clk); while (!(rx_if.valid && rx_if.ready));
        beats_sent++;
    endtask

    // Whole receive buffer; buffer_end rides on its last byte
    task automatic send_buffer(input logic [7:0] bytes_q[$]);
        foreach (bytes_q[i]) send_beat(bytes_q[i], i == bytes_q.size() - 1);
    endtask

    // Text frame header, optional key, and at most pay_cap payload bytes
    function automatic void push_text_frame(ref logic [7:0] q[$], input bit masked,
            input int unsigned len, input bit ext_len, input int unsigned pay_cap);
        logic [7:0] hdr;
        hdr = 8'($urandom);
        hdr[3:0] = OPC_TEXT;
        q = {q, hdr};
        if (ext_len || len >= 126) begin
            q = {q, {masked, LEN_EXT16}};
            q = {q, len[15:8]};
            q = {q, len[7:0]};
        end else begin
            q = {q, {masked, len[6:0]}};
        end
        if (masked) repeat (4) q = {q, 8'($urandom)};
        for (int i = 0; i < len && i < pay_cap; i++) q = {q, 8'($urandom)};
    endfunction

    // Mostly short payloads, some 7-bit maximum lengths, a few 16-bit lengths
    function automatic int unsigned pick_len(output bit ext);
        int unsigned sel;
        sel = $urandom_range(0, 99);
        ext = 1'b0;
        if (sel < 70) return $urandom_range(0, 12);
        if (sel < 88) return $urandom_range(13, 125);
        ext = 1'b1;
        if (sel < 94) return $urandom_range(0, 4);
        return $urandom_range(126, 200);
    endfunction

    // Result side: random stall before each beat
    initial begin : result_sink
        int unsigned stall;
        frm_if.ready = 1'b0;
        do @(posedge i_clk); while (!i_rst_n);
        forever begin
            stall = steady ? 0 : $urandom_range(0, MAX_WAIT);
            if (stall > 0) begin
                frm_if.ready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            frm_if.ready <= 1'b1;
            do @(posedge i_clk); while (!(frm_if.valid && frm_if.ready));
        end
    end

    // Accepted beats on both sides go to the scoreboard
    always @(posedge i_clk) begin
        t_result got;
        if (i_rst_n) begin
            if (rx_if.valid && rx_if.ready)
                sb.note_rx_beat(rx_if.rx_byte, rx_if.buffer_end);
            if (frm_if.valid && frm_if.ready) begin
                got.payload_byte = frm_if.payload_byte;
                got.has_byte     = frm_if.has_byte;
                got.frame_last   = frm_if.frame_last;
                got.status       = t_status'(frm_if.status);
                sb.check_result(got);
            end
        end
    end

    initial begin : stimulus
        logic [7:0]  buf_q[$];
        logic [7:0]  b;
        int unsigned kind;
        int unsigned cut;
        int unsigned len;
        int unsigned start_beats;
        bit          masked;
        bit          ext;
        sb               = new();
        steady           = 1'b0;
        beats_sent       = 0;
        rx_if.valid      = 1'b0;
        rx_if.rx_byte    = 8'h00;
        rx_if.buffer_end = 1'b0;
        i_rst_n          = 1'b0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed: close, bad opcode with trailing byte, each truncation point,
        // 64-bit length code, empty payload, masked and unmasked payloads
        buf_q = {8'h88};                                  send_buffer(buf_q);
        buf_q = {8'hFF, 8'h00};                           send_buffer(buf_q);
        buf_q = {8'h81};                                  send_buffer(buf_q);
        buf_q = {8'h81, 8'hFF};                           send_buffer(buf_q);
        buf_q = {8'h81, 8'h7E, 8'h01};                    send_buffer(buf_q);
        buf_q = {8'h01, 8'h00};                           send_buffer(buf_q);
        buf_q = {8'h81, 8'h80, 8'hA5};                    send_buffer(buf_q);
        buf_q = {8'h81, 8'h81, 8'h12, 8'h34, 8'h56, 8'h78, 8'hFF};
        send_buffer(buf_q);
        buf_q = {8'h81, 8'h03, 8'hFF, 8'h00};             send_buffer(buf_q);
        buf_q = {8'hF1, 8'h02, 8'h55, 8'hAA, 8'hC3};      send_buffer(buf_q);

        // random buffers: mostly well-formed frames, mixed with truncations, 64-bit length codes, errors, noise
        start_beats = beats_sent;
        while (beats_sent - start_beats < RANDOM_BEATS) begin
            if (steady) begin
                if ($urandom_range(0, 3) == 0) steady = 1'b0;
            end else if ($urandom_range(0, 11) == 0) begin
                steady = 1'b1;
            end
            buf_q.delete();
            kind   = $urandom_range(0, 99);
            masked = $urandom_range(0, 3) != 0;
            if (kind < 60) begin
                len = pick_len(ext);
                push_text_frame(buf_q, masked, len, ext, len);
                if ($urandom_range(0, 1) != 0)
                    repeat ($urandom_range(1, 4)) buf_q = {buf_q, 8'($urandom)};
            end else if (kind < 80) begin
                if ($urandom_range(0, 5) == 0) begin
                    b = 8'($urandom);
                    b[3:0] = OPC_TEXT;
                    buf_q = {buf_q, b};
                    buf_q = {buf_q, {masked, LEN_EXT64}};
                    repeat ($urandom_range(0, 6)) buf_q = {buf_q, 8'($urandom)};
                end else begin
                    if ($urandom_range(0, 2) == 0) begin
                        ext = 1'b1;
                        len = ($urandom_range(0, 3) == 0) ? 16'hFFFF : $urandom_range(0, 65535);
                    end else begin
                        len = pick_len(ext);
                    end
                    push_text_frame(buf_q, masked, len, ext, 12);
                    cut = $urandom_range(1, buf_q.size());
                    while (buf_q.size() > cut) void'(buf_q.pop_back());
                end
            end else if (kind < 90) begin
                do b = 8'($urandom); while (b[3:0] == OPC_TEXT);
                if ($urandom_range(0, 1) != 0) b[3:0] = OPC_CLOSE;
                buf_q = {buf_q, b};
                repeat ($urandom_range(0, 3)) buf_q = {buf_q, 8'($urandom)};
            end else begin
                repeat ($urandom_range(1, 6)) buf_q = {buf_q, 8'($urandom)};
            end
            send_buffer(buf_q);
        end
        rx_if.valid <= 1'b0;

        // drain, then let the pipeline settle
        while (sb.expected_q.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (sb.mismatch_count == 0 && sb.expected_q.size() == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

    // hard stop if the run hangs
    initial begin : run_limit
        #(RUN_LIMIT);
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
